/* src/sha1_pkg.sv */
// Package for the SHA-1 engine: constants, queue entry type, round helpers.
// No dependencies.
`default_nettype none
package sha1_pkg;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam int         QDEPTH   = 2;
    localparam int         QAW      = $clog2(QDEPTH);

    // Front-end classified item.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_COMP,
        S_PAD,
        S_OUT
    } t_state;

    function automatic logic [31:0] rnd_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20)      f = (b & c) | (~b & d);
        else if (r < 7'd40) f = b ^ c ^ d;
        else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                f = b ^ c ^ d;
        return f;
    endfunction

    function automatic logic [31:0] rnd_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)      k = K0;
        else if (r < 7'd40) k = K1;
        else if (r < 7'd60) k = K2;
        else                k = K3;
        return k;
    endfunction

endpackage
`default_nettype wire

/* src/sha1_if.sv */
// Valid/ready channel interfaces for the SHA-1 engine.
// Depends on nothing.
`default_nettype none
interface sha1_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        is_last;
    modport source (output valid, data_word, byte_count, is_last, input ready);
    modport sink   (input valid, data_word, byte_count, is_last, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* src/sha1_hash_engine.sv */
// Top level of the SHA-1 engine: front-end queue and compression back end.
// Depends on sha1_pkg, sha1_if, sha1_front and sha1_back.
//
// Streaming SHA-1: each item carries up to four big-endian message bytes; the
// item with is_last gets padded and yields five digest items, word 0 first.
// The back end takes an item, packs its bytes one per cycle and then closes it;
// each full 64-byte block pauses the packing for the single shared round unit
// (80 rounds and the fold), during which no item is taken. The last item adds
// one padding byte per cycle to the end of one or two blocks, each compressed in
// the same way, and then the five digest items go out, held while not ready.
// A two-entry queue in front decouples input from the core.
`default_nettype none
module sha1_hash_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sha1_in_if.sink     i_in,
    sha1_out_if.source  o_out
);
    sha1_pkg::t_item item;
    logic item_valid, item_pop;

    sha1_front u_front (
        .i_clk, .i_rst_n, .i_in,
        .o_item(item), .o_item_valid(item_valid), .i_item_pop(item_pop)
    );

    sha1_back u_back (
        .i_clk, .i_rst_n,
        .i_item(item), .i_item_valid(item_valid), .o_item_pop(item_pop),
        .o_out
    );

`ifndef ASSERT_OFF
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_pop |-> item_valid) else $error("pop from empty queue");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last_word |-> o_out.word_index == 3'd4)
        else $error("last word index");
`endif
endmodule
`default_nettype wire

/* src/sha1_front.sv */
// Front end: accepts input items, clamps byte count, queues them.
// Depends on sha1_pkg and sha1_in_if.
`default_nettype none
module sha1_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    sha1_in_if.sink        i_in,
    output sha1_pkg::t_item o_item,
    output logic           o_item_valid,
    input  wire            i_item_pop
);
    sha1_pkg::t_item r_q [sha1_pkg::QDEPTH];
    logic [sha1_pkg::QAW-1:0] r_wp, r_rp;
    logic [sha1_pkg::QAW:0]   r_cnt;
    logic push;

    assign i_in.ready   = (r_cnt != (sha1_pkg::QAW+1)'(sha1_pkg::QDEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].data <= i_in.data_word;
            r_q[r_wp].cnt  <= (i_in.byte_count > 3'd4) ? 3'd4 : i_in.byte_count;
            r_q[r_wp].last <= i_in.is_last;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_item_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (push ? 1'b1 : 1'b0) - (i_item_pop ? 1'b1 : 1'b0);
        end
    end
endmodule
`default_nettype wire

/* src/sha1_back.sv */
// Back end: byte packing, padding, 80-round compression, digest output.
// Depends on sha1_pkg and sha1_out_if.
`default_nettype none
module sha1_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  sha1_pkg::t_item i_item,
    input  wire             i_item_valid,
    output logic            o_item_pop,
    sha1_out_if.source      o_out
);
    sha1_pkg::t_state r_st, n_st;
    logic [31:0] r_h [5];
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [5:0]  r_pos;
    logic [63:0] r_len, r_flen;
    logic [6:0]  r_rnd;
    logic [2:0]  r_bi;
    logic [2:0]  r_oi;
    logic        r_pad;
    logic        r_mark;
    logic        r_fin;
    sha1_pkg::t_item r_it;

    logic [7:0]  cur_byte;
    logic [31:0] wx, wnew, tnew, wput;
    logic [3:0]  wi;
    logic        byte_full;
    logic        have_byte;

    assign wi        = r_pos[5:2];
    assign byte_full = (r_pos == 6'd63);
    assign have_byte = (r_bi < r_it.cnt);

    always_comb begin
        if (r_st == sha1_pkg::S_PAD) begin
            if (!r_mark)
                cur_byte = sha1_pkg::PAD_BYTE;
            else if (r_fin && r_pos >= sha1_pkg::LEN_POS)
                cur_byte = r_flen[{~r_pos[2:0], 3'b000} +: 8];
            else
                cur_byte = 8'h00;
        end else begin
            cur_byte = r_it.data[{~r_bi[1:0], 3'b000} +: 8];
        end
    end

    assign wput = (r_pos[1:0] == 2'd0) ? {cur_byte, 24'd0} :
                  (r_w[wi] | ({24'd0, cur_byte} << {~r_pos[1:0], 3'b000}));

    assign wx   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign wnew = {wx[30:0], wx[31]};
    assign tnew = {r_a[26:0], r_a[31:27]} + sha1_pkg::rnd_f(r_rnd, r_b, r_c, r_d) +
                  r_e + sha1_pkg::rnd_k(r_rnd) + r_w[0];

    assign o_item_pop        = (r_st == sha1_pkg::S_IDLE) && i_item_valid;
    assign o_out.valid       = (r_st == sha1_pkg::S_OUT);
    assign o_out.digest_word = r_h[r_oi];
    assign o_out.word_index  = r_oi;
    assign o_out.last_word   = (r_oi == 3'd4);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            sha1_pkg::S_IDLE: if (i_item_valid) n_st = sha1_pkg::S_BYTE;
            sha1_pkg::S_BYTE: begin
                if (have_byte) begin
                    if (byte_full) n_st = sha1_pkg::S_COMP;
                end else begin
                    n_st = r_it.last ? sha1_pkg::S_PAD : sha1_pkg::S_IDLE;
                end
            end
            sha1_pkg::S_PAD: if (byte_full) n_st = sha1_pkg::S_COMP;
            sha1_pkg::S_COMP: begin
                if (r_rnd == 7'd80) begin
                    if (!r_pad)     n_st = sha1_pkg::S_BYTE;
                    else if (r_fin) n_st = sha1_pkg::S_OUT;
                    else            n_st = sha1_pkg::S_PAD;
                end
            end
            sha1_pkg::S_OUT: if (o_out.ready && r_oi == 3'd4) n_st = sha1_pkg::S_IDLE;
            default: n_st = sha1_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= sha1_pkg::S_IDLE;
        else          r_st <= n_st;
    end

    // r_pad: padding under way; r_mark: 0x80 placed; r_fin: block being filled holds the length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_rnd  <= '0;
            r_bi   <= '0;
            r_oi   <= '0;
            r_pad  <= 1'b0;
            r_mark <= 1'b0;
            r_fin  <= 1'b0;
            r_h[0] <= sha1_pkg::IV0; r_h[1] <= sha1_pkg::IV1; r_h[2] <= sha1_pkg::IV2;
            r_h[3] <= sha1_pkg::IV3; r_h[4] <= sha1_pkg::IV4;
        end else begin
            unique case (r_st)
                sha1_pkg::S_IDLE: r_bi <= '0;
                sha1_pkg::S_BYTE: begin
                    r_rnd <= '0;
                    if (have_byte) begin
                        r_pos <= r_pos + 6'd1;
                        r_len <= r_len + 64'd8;
                        r_bi  <= r_bi + 3'd1;
                    end else if (r_it.last) begin
                        r_pad <= 1'b1;
                    end
                end
                sha1_pkg::S_PAD: begin
                    r_rnd <= '0;
                    r_pos <= r_pos + 6'd1;
                    if (!r_mark) begin
                        r_mark <= 1'b1;
                        if (r_pos < sha1_pkg::LEN_POS) r_fin <= 1'b1;
                    end
                end
                sha1_pkg::S_COMP: begin
                    if (r_rnd != 7'd80) begin
                        r_rnd <= r_rnd + 7'd1;
                    end else begin
                        r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                        r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                        r_h[4] <= r_h[4] + r_e;
                        if (r_pad) r_fin <= 1'b1;
                    end
                end
                sha1_pkg::S_OUT: if (o_out.ready) begin
                    if (r_oi == 3'd4) begin
                        r_oi <= '0;
                        r_h[0] <= sha1_pkg::IV0; r_h[1] <= sha1_pkg::IV1;
                        r_h[2] <= sha1_pkg::IV2; r_h[3] <= sha1_pkg::IV3;
                        r_h[4] <= sha1_pkg::IV4;
                        r_pos  <= '0;
                        r_len  <= '0;
                        r_pad  <= 1'b0;
                        r_mark <= 1'b0;
                        r_fin  <= 1'b0;
                    end else r_oi <= r_oi + 3'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            sha1_pkg::S_IDLE: r_it <= i_item;
            sha1_pkg::S_BYTE: begin
                if (have_byte) r_w[wi] <= wput;
                else           r_flen  <= r_len;
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
            end
            sha1_pkg::S_PAD: begin
                r_w[wi] <= wput;
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
            end
            sha1_pkg::S_COMP: begin
                if (r_rnd != 7'd80) begin
                    r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a; r_a <= tnew;
                    for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
                    r_w[15] <= wnew;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
